/* rtl/tcg_pkg.sv */
// Shared types and constants of the text console grid.
// Holds the beat structs of both channels and the controller/datapath interface.
// No dependencies.
`timescale 1ns / 1ps

package tcg_pkg;

    localparam int DEF_NUM_COLS = 100;
    localparam int DEF_NUM_ROWS = 60;
    localparam int DEF_TAB_STOP = 8;

    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic KIND_PUT  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] char_code;
        logic [5:0] read_row;
        logic [6:0] read_col;
    } in_item_t;

    typedef struct packed {
        logic [5:0] cursor_row;
        logic [6:0] cursor_col;
        logic [7:0] cell_char;
        logic       changed;
    } out_item_t;

    typedef struct packed {
        logic init_wr;
        logic load_item;
        logic rd_issue;
        logic cap_cell;
        logic newline;
        logic backspace;
        logic put_char;
        logic put_space;
        logic scroll_wr;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic init_last;
        logic is_read;
        logic rd_in_range;
        logic is_cr;
        logic is_lf;
        logic is_bs;
        logic is_tab;
        logic col_last;
        logic row_last;
        logic tab_last;
        logic scroll_last;
        logic out_free;
    } status_t;

endpackage

/* rtl/tcg_datapath.sv */
// Datapath of the text console grid: cell memory, cursor, scroll offset and
// the result register. Driven by tcg_controller through tcg_pkg::cmd_t.
// Depends on tcg_pkg.
`timescale 1ns / 1ps

module tcg_datapath #(
    parameter int NUM_COLS = tcg_pkg::DEF_NUM_COLS,
    parameter int NUM_ROWS = tcg_pkg::DEF_NUM_ROWS,
    parameter int TAB_STOP = tcg_pkg::DEF_TAB_STOP
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  tcg_pkg::cmd_t      cmd,
    output tcg_pkg::status_t   status,
    input  tcg_pkg::in_item_t  s_item,
    output tcg_pkg::out_item_t m_item,
    output logic               m_valid,
    input  logic               m_ready
);
    import tcg_pkg::*;

    localparam int DEPTH  = NUM_ROWS * NUM_COLS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int COL_W  = $clog2(NUM_COLS);
    localparam int ROW_W  = $clog2(NUM_ROWS);
    localparam int PH_W   = $clog2(TAB_STOP);
    localparam int SUM_W  = ROW_W + 1;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(NUM_COLS);
    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(NUM_COLS - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(NUM_ROWS - 1);
    localparam logic [PH_W-1:0]   LAST_PH   = PH_W'(TAB_STOP - 1);
    localparam logic [SUM_W-1:0]  ROWS_S    = SUM_W'(NUM_ROWS);

    logic [7:0] cell_mem [DEPTH];
    logic [7:0] rd_data_reg;

    in_item_t    item_reg, item_next;
    logic [7:0]  cell_reg, cell_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [PH_W-1:0]  phase_reg, phase_next;
    logic [ROW_W-1:0] top_reg, top_next;
    logic [COL_W-1:0] scnt_reg, scnt_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    out_item_t   out_reg, out_next;
    logic        m_valid_reg, m_valid_next;

    logic [ROW_W-1:0]  sel_row, prow;
    logic [COL_W-1:0]  sel_col;
    logic [SUM_W-1:0]  row_sum;
    logic [ADDR_W-1:0] mem_addr;
    logic [7:0]        mem_wdata;
    logic              mem_we;
    logic              adv_line;

    // Address of the cell being touched this cycle. Visible rows map onto
    // physical rows through the ring offset; the scroll sweep uses the old
    // top row directly.
    always_comb begin
        sel_row = cmd.rd_issue ? ROW_W'(item_reg.read_row) : row_reg;
        sel_col = cmd.rd_issue ? COL_W'(item_reg.read_col) :
                  (cmd.scroll_wr ? scnt_reg : col_reg);
        row_sum = {1'b0, top_reg} + {1'b0, sel_row};
        if (cmd.scroll_wr) begin
            prow = top_reg;
        end else if (row_sum >= ROWS_S) begin
            prow = ROW_W'(row_sum - ROWS_S);
        end else begin
            prow = ROW_W'(row_sum);
        end
        if (cmd.init_wr) begin
            mem_addr = clr_reg;
        end else begin
            mem_addr = ADDR_W'(ADDR_W'(prow) * COLS_A) + ADDR_W'(sel_col);
        end
        mem_we    = cmd.init_wr | cmd.scroll_wr | cmd.put_char | cmd.put_space;
        mem_wdata = cmd.put_char ? item_reg.char_code : CH_SPACE;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            cell_mem[mem_addr] <= mem_wdata;
        end
        rd_data_reg <= cell_mem[mem_addr];
    end

    always_comb begin
        status.init_last   = (clr_reg == LAST_ADDR);
        status.is_read     = (item_reg.kind == KIND_READ);
        status.rd_in_range = (32'(item_reg.read_row) < NUM_ROWS) &&
                             (32'(item_reg.read_col) < NUM_COLS);
        status.is_cr       = (item_reg.char_code == CH_CR);
        status.is_lf       = (item_reg.char_code == CH_LF);
        status.is_bs       = (item_reg.char_code == CH_BS);
        status.is_tab      = (item_reg.char_code == CH_TAB);
        status.col_last    = (col_reg == LAST_COL);
        status.row_last    = (row_reg == LAST_ROW);
        status.tab_last    = (phase_reg == LAST_PH) || (col_reg == LAST_COL);
        status.scroll_last = (scnt_reg == LAST_COL);
        status.out_free    = !m_valid_reg || m_ready;
    end

    always_comb begin
        item_next    = item_reg;
        cell_next    = cell_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        phase_next   = phase_reg;
        top_next     = top_reg;
        scnt_next    = scnt_reg;
        clr_next     = clr_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg;

        adv_line = cmd.newline |
                   ((cmd.put_char | cmd.put_space) & (col_reg == LAST_COL));

        if (cmd.load_item) begin
            item_next = s_item;
            cell_next = 8'd0;
        end
        if (cmd.cap_cell) begin
            cell_next = rd_data_reg;
        end
        if (cmd.init_wr) begin
            clr_next = clr_reg + 1'b1;
        end
        if (cmd.backspace && col_reg != '0) begin
            col_next   = col_reg - 1'b1;
            phase_next = (phase_reg == '0) ? LAST_PH : phase_reg - 1'b1;
        end
        if (adv_line) begin
            col_next   = '0;
            phase_next = '0;
            if (row_reg == LAST_ROW) begin
                scnt_next = '0;
            end else begin
                row_next = row_reg + 1'b1;
            end
        end else if (cmd.put_char | cmd.put_space) begin
            col_next   = col_reg + 1'b1;
            phase_next = (phase_reg == LAST_PH) ? '0 : phase_reg + 1'b1;
        end
        if (cmd.scroll_wr) begin
            scnt_next = scnt_reg + 1'b1;
            if (scnt_reg == LAST_COL) begin
                top_next = (top_reg == LAST_ROW) ? '0 : top_reg + 1'b1;
            end
        end

        if (cmd.out_load) begin
            out_next.cursor_row = 6'(row_reg);
            out_next.cursor_col = 7'(col_reg);
            out_next.cell_char  = cell_reg;
            out_next.changed    = (item_reg.kind == KIND_PUT) &&
                                  (item_reg.char_code != CH_CR);
            m_valid_next        = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg     <= '0;
            col_reg     <= '0;
            phase_reg   <= '0;
            top_reg     <= '0;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            row_reg     <= row_next;
            col_reg     <= col_next;
            phase_reg   <= phase_next;
            top_reg     <= top_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        cell_reg <= cell_next;
        scnt_reg <= scnt_next;
        out_reg  <= out_next;
    end

    assign m_item  = out_reg;
    assign m_valid = m_valid_reg;

    a_col_range : assert property (@(posedge aclk) disable iff (!aresetn)
        32'(col_reg) < NUM_COLS)
        else $error("cursor column left the grid");

    a_row_range : assert property (@(posedge aclk) disable iff (!aresetn)
        (32'(row_reg) < NUM_ROWS) && (32'(top_reg) < NUM_ROWS))
        else $error("cursor row or top offset left the grid");

    a_load_free : assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten before its beat was taken");

    a_scroll_pos : assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scroll_wr |-> (row_reg == LAST_ROW) && (col_reg == '0))
        else $error("row clear while cursor is not at the start of the last row");

    a_load_valid : assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid_reg)
        else $error("loaded result did not raise valid");

endmodule

/* rtl/tcg_controller.sv */
// Sequencer of the text console grid: clearing pass, item dispatch, tab fill,
// row clear on scroll and result handoff. Drives tcg_datapath.
// Depends on tcg_pkg.
`timescale 1ns / 1ps

module tcg_controller (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  tcg_pkg::status_t status,
    output tcg_pkg::cmd_t    cmd
);
    import tcg_pkg::*;

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_EXEC   = 3'd2;
    localparam logic [2:0] S_RDWAIT = 3'd3;
    localparam logic [2:0] S_TAB    = 3'd4;
    localparam logic [2:0] S_SCROLL = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0] state_reg, state_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_INIT: begin
                cmd.init_wr = 1'b1;
                if (status.init_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC: begin
                priority if (status.is_read) begin
                    if (status.rd_in_range) begin
                        cmd.rd_issue = 1'b1;
                        state_next   = S_RDWAIT;
                    end else begin
                        state_next = S_DONE;
                    end
                end else if (status.is_cr) begin
                    state_next = S_DONE;
                end else if (status.is_lf) begin
                    cmd.newline = 1'b1;
                    state_next  = status.row_last ? S_SCROLL : S_DONE;
                end else if (status.is_bs) begin
                    cmd.backspace = 1'b1;
                    state_next    = S_DONE;
                end else if (status.is_tab) begin
                    state_next = S_TAB;
                end else begin
                    cmd.put_char = 1'b1;
                    state_next   = (status.col_last && status.row_last) ? S_SCROLL : S_DONE;
                end
            end
            S_RDWAIT: begin
                cmd.cap_cell = 1'b1;
                state_next   = S_DONE;
            end
            S_TAB: begin
                // One space per cycle until the tab stop or the right edge.
                cmd.put_space = 1'b1;
                if (status.tab_last) begin
                    state_next = (status.col_last && status.row_last) ? S_SCROLL : S_DONE;
                end
            end
            S_SCROLL: begin
                cmd.scroll_wr = 1'b1;
                if (status.scroll_last) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/text_console_grid.sv */
// Top level of the text console grid: controller plus datapath.
// Depends on tcg_pkg, tcg_controller and tcg_datapath.
//
// Usage: each beat on the s_ channel is either a put (kind 0) of one character
// byte or a read (kind 1) of one visible cell. Every beat yields exactly one
// result beat on the m_ channel with the cursor after the item, the read cell
// (zero for puts) and a changed flag. Both channels use valid/ready.
//
// Sequence from the accepting edge to the result entering the output register:
// CR, LF, backspace, printable characters and reads outside the grid finish in
// the execute state; a read inside the grid adds the read-wait state, and a tab
// writes spaces up to the tab stop (up to TAB_STOP) or the right edge. A move
// past the last row then clears that row, one cell at a time through the single
// memory port. The next beat is taken only after the result has been loaded.
//
// After reset the block clears the cell memory to spaces, one cell per cycle,
// all NUM_ROWS*NUM_COLS cells (6000 by default), with s_ready low. The result
// register decouples the two sides: a new beat is accepted while the previous
// result waits, and the sequencer holds a finished result until m_ready frees
// the register.
`timescale 1ns / 1ps

module text_console_grid #(
    parameter int NUM_COLS = tcg_pkg::DEF_NUM_COLS,
    parameter int NUM_ROWS = tcg_pkg::DEF_NUM_ROWS,
    parameter int TAB_STOP = tcg_pkg::DEF_TAB_STOP
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  tcg_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output tcg_pkg::out_item_t m_item
);
    import tcg_pkg::*;

    cmd_t    cmd;
    status_t status;

    tcg_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tcg_datapath #(
        .NUM_COLS (NUM_COLS),
        .NUM_ROWS (NUM_ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .status  (status),
        .s_item  (s_item),
        .m_item  (m_item),
        .m_valid (m_valid),
        .m_ready (m_ready)
    );

endmodule

/* verif/text_console_grid_tb.sv */
// Self-checking testbench for the text console grid.
// Predicts each result beat from a shadow copy of the cell grid and cursor.
// Depends on tcg_pkg and text_console_grid.
`timescale 1ns / 1ps

module text_console_grid_tb;

    import tcg_pkg::*;

    localparam int COLS         = DEF_NUM_COLS;
    localparam int ROWS         = DEF_NUM_ROWS;
    localparam int TAB_W        = DEF_TAB_STOP;
    localparam int ITEM_TARGET  = 1650;
    localparam int CALM_ITEMS   = 200;
    localparam int LONG_HOLD    = 400;
    localparam int HOLD_AT      = 300;
    localparam int PAUSE_AT     = 700;
    localparam int DRAIN_CYCLES = 250;
    localparam int MAX_REPORTS  = 100;

    // Shadow of the console: cell grid, cursor and scroll offset, plus the
    // result beats still owed by the block.
    class grid_scoreboard;
        logic [7:0]  cells [ROWS][COLS];
        int unsigned cur_row;
        int unsigned cur_col;
        int unsigned top_row;
        out_item_t   awaited[$];
        int unsigned mismatches;

        function new();
            foreach (cells[r, c]) cells[r][c] = CH_SPACE;
            cur_row    = 0;
            cur_col    = 0;
            top_row    = 0;
            mismatches = 0;
        endfunction

        function void line_feed();
            cur_col = 0;
            cur_row++;
            if (cur_row >= ROWS) begin
                // The old top row is blanked and becomes the new bottom row.
                for (int c = 0; c < COLS; c++) cells[top_row][c] = CH_SPACE;
                top_row = (top_row + 1) % ROWS;
                cur_row = ROWS - 1;
            end
        endfunction

        function void write_at_cursor(logic [7:0] ch);
            if (cur_col < COLS) cells[(top_row + cur_row) % ROWS][cur_col] = ch;
        endfunction

        function void accept_item(in_item_t it);
            out_item_t   rep;
            int unsigned tab_end;
            rep = '0;
            if (it.kind == KIND_READ) begin
                if (it.read_row < ROWS && it.read_col < COLS)
                    rep.cell_char = cells[(top_row + it.read_row) % ROWS][it.read_col];
            end else if (it.char_code != CH_CR) begin
                rep.changed = 1'b1;
                case (it.char_code)
                    CH_LF: begin
                        line_feed();
                    end
                    CH_BS: begin
                        if (cur_col > 0) cur_col--;
                    end
                    CH_TAB: begin
                        tab_end = cur_col + TAB_W - (cur_col % TAB_W);
                        while (cur_col < tab_end && cur_col < COLS) begin
                            write_at_cursor(CH_SPACE);
                            cur_col++;
                        end
                        if (cur_col >= COLS) line_feed();
                    end
                    default: begin
                        write_at_cursor(it.char_code);
                        cur_col++;
                        if (cur_col >= COLS) line_feed();
                    end
                endcase
            end
            rep.cursor_row = 6'(cur_row);
            rep.cursor_col = 7'(cur_col);
            awaited.push_back(rep);
        endfunction

        function void report(string field, int unsigned want_v, int unsigned got_v);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, field, want_v, got_v);
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected beat, row %0d col %0d char %0d changed %0d",
                             $time, got.cursor_row, got.cursor_col, got.cell_char,
                             got.changed);
                return;
            end
            want = awaited.pop_front();
            if (got.cursor_row !== want.cursor_row)
                report("cursor_row", want.cursor_row, got.cursor_row);
            if (got.cursor_col !== want.cursor_col)
                report("cursor_col", want.cursor_col, got.cursor_col);
            if (got.cell_char !== want.cell_char)
                report("cell_char", want.cell_char, got.cell_char);
            if (got.changed !== want.changed)
                report("changed", want.changed, got.changed);
        endfunction

        function int unsigned pending();
            return awaited.size();
        endfunction
    endclass

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    grid_scoreboard sb = new();

    bit          calm           = 1'b0;
    bit          rx_hold        = 1'b0;
    bit          long_hold_done = 1'b0;
    int unsigned items_sent     = 0;
    int unsigned reports_seen   = 0;

    text_console_grid dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic in_item_t put_of(logic [7:0] ch);
        in_item_t it;
        it.kind      = KIND_PUT;
        it.char_code = ch;
        it.read_row  = 6'($urandom);
        it.read_col  = 7'($urandom);
        return it;
    endfunction

    function automatic in_item_t read_of(int unsigned row, int unsigned col);
        in_item_t it;
        it.kind      = KIND_READ;
        it.char_code = 8'($urandom);
        it.read_row  = row[5:0];
        it.read_col  = col[6:0];
        return it;
    endfunction

    function automatic in_item_t noise_item();
        in_item_t it;
        it.kind      = 1'($urandom);
        it.char_code = 8'($urandom);
        it.read_row  = 6'($urandom);
        it.read_col  = 7'($urandom);
        return it;
    endfunction

    // Offers one beat and holds it until the block takes it.
    task automatic send_item(input in_item_t it);
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        sb.accept_item(it);
        items_sent++;
        if (items_sent >= ITEM_TARGET - CALM_ITEMS) calm = 1'b1;
        if (!calm && !rx_hold && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
    endtask

    // Stops offering beats until every owed result has come back.
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    initial begin
        int unsigned line_len;
        int unsigned pick;
        bit          paused_once;
        paused_once = 1'b0;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        send_item(read_of(0, 0));
        send_item(put_of(8'h41));
        send_item(put_of(8'h00));
        send_item(put_of(8'hFF));
        send_item(put_of(CH_CR));
        // The last backspace finds the cursor already at column 0.
        repeat (4) send_item(put_of(CH_BS));
        send_item(put_of(CH_TAB));
        send_item(put_of(8'h7E));
        send_item(put_of(CH_TAB));
        send_item(put_of(CH_LF));
        send_item(read_of(0, 0));
        send_item(read_of(0, 1));
        send_item(read_of(0, 2));
        send_item(read_of(0, 8));
        send_item(read_of(ROWS - 1, COLS - 1));
        send_item(read_of(ROWS, 0));
        send_item(read_of(0, COLS));
        send_item(read_of(63, 127));
        drain();

        // Mostly lines of text with edits and reads mixed in, so the cursor
        // wraps, tabs run into the right edge and the screen scrolls.
        while (items_sent < ITEM_TARGET) begin
            if (!paused_once && items_sent >= PAUSE_AT) begin
                paused_once = 1'b1;
                drain();
            end
            if ($urandom_range(0, 9) == 0) begin
                send_item(noise_item());
            end else begin
                line_len = ($urandom_range(0, 7) == 0) ? $urandom_range(90, 110)
                                                       : $urandom_range(0, 12);
                for (int k = 0; k < line_len; k++) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 6)
                        send_item(put_of(CH_TAB));
                    else if (pick < 10)
                        send_item(put_of(CH_BS));
                    else if (pick < 12)
                        send_item(put_of(CH_CR));
                    else if (pick < 20)
                        send_item(read_of($urandom_range(0, ROWS - 1), $urandom_range(0, 15)));
                    else if (pick < 26)
                        send_item(read_of($urandom_range(0, ROWS - 1),
                                          $urandom_range(0, COLS - 1)));
                    else if (pick < 60)
                        send_item(put_of(8'($urandom_range(32, 126))));
                    else
                        send_item(put_of(8'($urandom_range(0, 255))));
                end
                if ($urandom_range(0, 99) < 85) send_item(put_of(CH_LF));
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        int unsigned stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                sb.check_result(m_item);
                reports_seen++;
            end
            if (!long_hold_done && reports_seen >= HOLD_AT) begin
                // Long hold-off: the sender keeps offering, so the block backs up.
                long_hold_done = 1'b1;
                rx_hold        = 1'b1;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                rx_hold = 1'b0;
                m_ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 11) == 0) begin
                stall_left = $urandom_range(0, 9);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        #(10_000_000);
        $display("status: fail");
        $finish;
    end

endmodule
